@@ rtl/pp_pkg.sv @@
// ----------------------------------------------------------------------------
// pp_pkg
// Shared constants and controller/datapath bundles for the polygon perimeter
// block.
// ----------------------------------------------------------------------------
package pp_pkg;

   localparam int MAX_VERTS  = 16;              // vertices kept per polygon
   localparam int MIN_VERTS  = 3;               // fewer than this is flagged
   localparam int COORD_W    = 24;              // Q12.12 coordinate
   localparam int DIFF_W     = COORD_W + 1;     // exact difference / magnitude
   localparam int SQ_W       = 2 * DIFF_W;      // dx^2 + dy^2, Q.24
   localparam int ROOT_W     = SQ_W / 2;        // edge length, Q.12
   localparam int REM_W      = ROOT_W + 1;      // square root remainder
   localparam int SUM_W      = 30;              // perimeter, Q18.12
   localparam int CNT_W      = $clog2(MAX_VERTS + 1);
   localparam int SQRT_STEPS = SQ_W / 2;        // two radicand bits per step
   localparam int STEP_W     = $clog2(SQRT_STEPS);

   typedef struct packed {
      logic load_in;     // capture accepted vertex
      logic take_first;  // vertex becomes first and previous
      logic set_ovf;     // vertex dropped past the limit
      logic close_sel;   // edge runs previous -> first
      logic diff;        // register |dx|, |dy|
      logic mul_x;       // square |dx|
      logic mul_y;       // square |dy|
      logic root_load;   // form radicand, clear root
      logic root_step;   // one root digit
      logic acc_edge;    // add length, advance previous vertex
      logic acc_close;   // add closing length only
      logic emit;        // load result, clear polygon state
   } pp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic last;
   } pp_stat_type;

endpackage

@@ rtl/pp_channels.sv @@
// ----------------------------------------------------------------------------
// pp channels
// Valid/ready channels for vertex items and perimeter result items.
// ----------------------------------------------------------------------------
interface pp_req_if;
   import pp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] x_coord;
   logic signed [COORD_W-1:0] y_coord;
   logic                      last_vertex;

   modport source (output valid, x_coord, y_coord, last_vertex, input ready);
   modport sink   (input valid, x_coord, y_coord, last_vertex, output ready);
endinterface

interface pp_rsp_if;
   import pp_pkg::*;

   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] perimeter;
   logic             too_few_vertices;
   logic             truncated;

   modport source (output valid, perimeter, too_few_vertices, truncated, input ready);
   modport sink   (input valid, perimeter, too_few_vertices, truncated, output ready);
endinterface

@@ rtl/polygon_perimeter.sv @@
// ----------------------------------------------------------------------------
// polygon_perimeter
// Perimeter of one closed polygon streamed as Q12.12 vertex items.
// ----------------------------------------------------------------------------
// An inner vertex passes accept, decide, difference, two squares, radicand,
//   25 root steps and accumulate; the first vertex only accept and decide.
// The last vertex adds a closing edge through the same steps to the result.
// One vertex is taken at a time; the 25-step square root sets the rate.
// A finished result waits in the output register while the next polygon's
//   vertices are taken. Synchronous reset clears all polygon state.
// ----------------------------------------------------------------------------
module polygon_perimeter (
   input  logic     clock,
   input  logic     reset,
   pp_req_if.sink   req_chan,
   pp_rsp_if.source rsp_chan
);
   import pp_pkg::*;

   pp_cmd_type  cmd;    // sequencer -> datapath
   pp_stat_type stat;   // datapath -> sequencer

   // controller: takes a vertex only when idle, runs its edge, the closing edge, both or neither
   pp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath: vertices, shared squarer, root unit, sum and result register
   pp_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .in_x             (req_chan.x_coord),
      .in_y             (req_chan.y_coord),
      .in_last          (req_chan.last_vertex),
      .perimeter        (rsp_chan.perimeter),
      .too_few_vertices (rsp_chan.too_few_vertices),
      .truncated        (rsp_chan.truncated)
   );

endmodule

@@ rtl/pp_datapath.sv @@
// ----------------------------------------------------------------------------
// pp_datapath
// Vertex registers, edge difference, shared squarer, digit-by-digit square
// root, saturating perimeter sum and result register.
// ----------------------------------------------------------------------------
module pp_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  pp_pkg::pp_cmd_type                cmd,
   output pp_pkg::pp_stat_type               stat,
   input  logic signed [pp_pkg::COORD_W-1:0] in_x,
   input  logic signed [pp_pkg::COORD_W-1:0] in_y,
   input  logic                              in_last,
   output logic [pp_pkg::SUM_W-1:0]          perimeter,
   output logic                              too_few_vertices,
   output logic                              truncated
);
   import pp_pkg::*;

   logic signed [COORD_W-1:0] cur_x_ff, cur_y_ff;
   logic                      last_ff;
   logic signed [COORD_W-1:0] first_x_ff, first_y_ff;
   logic signed [COORD_W-1:0] prev_x_ff, prev_y_ff;
   logic [SUM_W-1:0]          sum_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      ovf_ff;

   logic [DIFF_W-1:0]         dx_ff, dy_ff;
   logic [SQ_W-1:0]           mul_ff, sqx_ff, rad_ff;
   logic [REM_W-1:0]          rem_ff;
   logic [ROOT_W-1:0]         root_ff;

   logic [SUM_W-1:0]          perim_ff;
   logic                      few_ff, trunc_ff;

   logic signed [COORD_W-1:0] end_x, end_y;
   logic signed [DIFF_W-1:0]  dx_c, dy_c;
   logic [DIFF_W-1:0]         mop;
   logic [REM_W+1:0]          rem_sh, trial;
   logic [SUM_W:0]            sum_c;
   logic [SUM_W-1:0]          sum_sat;

   // edge end point: the new vertex, or the first one for the closing edge
   assign end_x = cmd.close_sel ? first_x_ff : cur_x_ff;
   assign end_y = cmd.close_sel ? first_y_ff : cur_y_ff;
   assign dx_c  = DIFF_W'(end_x) - DIFF_W'(prev_x_ff);
   assign dy_c  = DIFF_W'(end_y) - DIFF_W'(prev_y_ff);

   assign mop    = cmd.mul_y ? dy_ff : dx_ff;

   // restoring root: bring down two radicand bits, try 4*root+1
   assign rem_sh = {rem_ff, rad_ff[SQ_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   assign sum_c   = {1'b0, sum_ff} + (SUM_W + 1)'(root_ff);
   assign sum_sat = sum_c[SUM_W] ? {SUM_W{1'b1}} : sum_c[SUM_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         cur_x_ff <= in_x;
         cur_y_ff <= in_y;
         last_ff  <= in_last;
      end
      if (cmd.diff) begin
         dx_ff <= dx_c[DIFF_W-1] ? DIFF_W'(-dx_c) : DIFF_W'(dx_c);
         dy_ff <= dy_c[DIFF_W-1] ? DIFF_W'(-dy_c) : DIFF_W'(dy_c);
      end
      if (cmd.mul_x || cmd.mul_y) begin
         mul_ff <= SQ_W'(mop) * SQ_W'(mop);
      end
      if (cmd.mul_y) begin
         sqx_ff <= mul_ff;
      end
      if (cmd.root_load) begin
         rad_ff  <= sqx_ff + mul_ff;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff <= {rad_ff[SQ_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= REM_W'(rem_sh - trial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= REM_W'(rem_sh);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.emit) begin
         perim_ff <= sum_ff;
         few_ff   <= (count_ff < CNT_W'(MIN_VERTS));
         trunc_ff <= ovf_ff;
      end
   end

   // polygon state
   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         first_x_ff <= '0;
         first_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         sum_ff     <= '0;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         if (cmd.take_first) begin
            first_x_ff <= cur_x_ff;
            first_y_ff <= cur_y_ff;
            prev_x_ff  <= cur_x_ff;
            prev_y_ff  <= cur_y_ff;
            count_ff   <= CNT_W'(1);
         end
         if (cmd.set_ovf) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.acc_edge) begin
            sum_ff    <= sum_sat;
            prev_x_ff <= cur_x_ff;
            prev_y_ff <= cur_y_ff;
            count_ff  <= count_ff + CNT_W'(1);
         end
         if (cmd.acc_close) begin
            sum_ff <= sum_sat;
         end
      end
   end

   assign stat.count_zero = (count_ff == '0);
   assign stat.count_full = (count_ff >= CNT_W'(MAX_VERTS));
   assign stat.last       = last_ff;

   assign perimeter        = perim_ff;
   assign too_few_vertices = few_ff;
   assign truncated        = trunc_ff;

endmodule

@@ rtl/pp_ctrl.sv @@
// ----------------------------------------------------------------------------
// pp_ctrl
// Sequencer: accepts a vertex, runs its edge, the closing edge, both or
// neither, and hands the result to the output register.
// ----------------------------------------------------------------------------
module pp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pp_pkg::pp_cmd_type   cmd,
   input  pp_pkg::pp_stat_type  stat
);
   import pp_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECIDE, ST_DIFF, ST_MULX, ST_MULY,
      ST_LOAD, ST_ROOT, ST_ACC, ST_OUT
   } state_type;

   state_type         state_ff;
   logic              close_ff;
   logic [STEP_W-1:0] step_ff;
   logic              rsp_valid_ff;
   logic              slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd           = '0;
      cmd.close_sel = close_ff;
      unique case (state_ff)
         ST_IDLE:   cmd.load_in    = req_valid;
         ST_DECIDE: begin
            cmd.take_first = stat.count_zero;
            cmd.set_ovf    = !stat.count_zero && stat.count_full;
         end
         ST_DIFF:   cmd.diff       = 1'b1;
         ST_MULX:   cmd.mul_x      = 1'b1;
         ST_MULY:   cmd.mul_y      = 1'b1;
         ST_LOAD:   cmd.root_load  = 1'b1;
         ST_ROOT:   cmd.root_step  = 1'b1;
         ST_ACC: begin
            cmd.acc_edge  = !close_ff;
            cmd.acc_close = close_ff;
         end
         ST_OUT:    cmd.emit       = slot_free;
         default:   cmd            = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         close_ff     <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (!stat.count_zero && !stat.count_full) begin
                  close_ff <= 1'b0;
                  state_ff <= ST_DIFF;
               end else if (stat.last) begin
                  close_ff <= 1'b1;
                  state_ff <= ST_DIFF;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIFF:  state_ff <= ST_MULX;
            ST_MULX:  state_ff <= ST_MULY;
            ST_MULY:  state_ff <= ST_LOAD;
            ST_LOAD: begin
               step_ff  <= '0;
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               if (close_ff) begin
                  state_ff <= ST_OUT;
               end else if (stat.last) begin
                  close_ff <= 1'b1;
                  state_ff <= ST_DIFF;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_OUT: begin
               if (slot_free) begin
                  close_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/pp_checker.sv @@
// ----------------------------------------------------------------------------
// pp_checker
// Port-level checks for polygon_perimeter, bound to the top level.
// ----------------------------------------------------------------------------
module pp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [pp_pkg::SUM_W-1:0]   perimeter
);
   import pp_pkg::*;

   // a result never appears straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(perimeter))
      else $error("result dropped or changed while stalled");

   // an accepted item keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after an accept");

   // a new result is produced only while the input side is busy
   a_result_when_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid) && !$past(reset)) |-> !$past(req_ready))
      else $error("result appeared while input was idle");

endmodule

bind polygon_perimeter pp_checker u_pp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .perimeter (rsp_chan.perimeter)
);
